// File: hdl/mt4_pkg.sv
// Shared types, codes and defaults for the 4x4 matrix transform engine.
`timescale 1ns / 1ps

package mt4_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int ELEM_WIDTH_DEF = 32;

  localparam logic [2:0] KIND_LOAD_T    = 3'd0;
  localparam logic [2:0] KIND_LOAD_O    = 3'd1;
  localparam logic [2:0] KIND_IDENTITY  = 3'd2;
  localparam logic [2:0] KIND_TRANSPOSE = 3'd3;
  localparam logic [2:0] KIND_MULTIPLY  = 3'd4;
  localparam logic [2:0] KIND_TRANSFORM = 3'd5;

  // Token that walks down the chain of column cells.
  typedef struct packed {
    logic       vld;
    logic       mul;
    logic [1:0] row;
    logic [1:0] col;
  } tok_t;

  // Per-cell write controls.
  typedef struct packed {
    logic       t_en;
    logic [1:0] t_idx;
    logic       o_en;
    logic [1:0] o_idx;
    logic       col_ld;
  } cell_ctl_t;

endpackage

// File: hdl/mt4_in_if.sv
// Input channel interface carrying one command transaction.
`timescale 1ns / 1ps

interface mt4_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [1:0]         row_index;
  logic [1:0]         col_index;
  logic signed [31:0] element_value;
  logic signed [31:0] vec_x;
  logic signed [31:0] vec_y;
  logic signed [31:0] vec_z;
  logic signed [31:0] vec_w;

  modport source (output valid, kind, row_index, col_index, element_value,
                  vec_x, vec_y, vec_z, vec_w, input ready);
  modport sink (input valid, kind, row_index, col_index, element_value,
                vec_x, vec_y, vec_z, vec_w, output ready);
endinterface

// File: hdl/mt4_out_if.sv
// Result channel interface carrying one transformed vector.
`timescale 1ns / 1ps

interface mt4_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic signed [31:0] out_w;
  logic               saturated;

  modport source (output valid, out_x, out_y, out_z, out_w, saturated, input ready);
  modport sink (input valid, out_x, out_y, out_z, out_w, saturated, output ready);
endinterface

// File: hdl/matrix4_transform_engine_core.sv
// Top level: command decode, token issue, result collection and output register.
// A transform passes four tokens, one per result row, down the chain of four cells,
// two registers per cell; a multiply passes sixteen. Loads, identity and transpose
// are written when accepted. No new command is taken until a multiply or transform
// has finished and, for a transform, the output register is free to take its result.
// Reset (synchronous, active low) sets the transform to identity and clears control.
`timescale 1ns / 1ps

module matrix4_transform_engine_core import mt4_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input logic      clk,
  input logic      rst_n,
  mt4_in_if.sink   in_chan,
  mt4_out_if.source out_chan
);

  localparam int EW = ELEM_WIDTH;
  localparam int OW = (ELEM_WIDTH > 32) ? ELEM_WIDTH : 32;
  localparam int AW = EW + OW + 2;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t                      st_r, st_nxt;
  logic                        mode_mul_r;
  logic [4:0]                  iss_r, ret_r;
  logic [4:0]                  total;
  logic [3:0][OW-1:0]          vec_r;
  logic [3:0][31:0]            res_r;
  logic                        sat_r;
  logic [15:0][EW-1:0]         newm_r;
  logic                        out_vld_r;
  logic [3:0][31:0]            out_r;
  logic                        out_sat_r;

  logic                        in_acc;
  logic [EW-1:0]               load_val;
  logic [EW-1:0]               one_val;
  tok_t                        tok_w [5];
  logic signed [AW-1:0]        acc_w [5];
  logic [3:0][EW-1:0]          cols_w [4];
  logic [3:0][EW-1:0]          ld_w [4];
  cell_ctl_t                   ctl_w [4];
  logic                        col_ld;
  logic signed [AW-1:0]        sh;
  logic                        fit32, fitew;
  logic [31:0]                 sat32;
  logic [EW-1:0]               satew;
  logic                        fin_go;

  function automatic logic [EW-1:0] sat_ew(input logic signed [OW-1:0] v);
    logic fits;
    fits = (v[OW-1:EW-1] == {(OW-EW+1){v[EW-1]}});
    if (fits) return v[EW-1:0];
    return v[OW-1] ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
  endfunction

  assign in_chan.ready = (st_r == S_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign load_val      = sat_ew(OW'(in_chan.element_value));
  assign one_val       = sat_ew(OW'(1) << FRAC_BITS);
  assign total         = mode_mul_r ? 5'd16 : 5'd4;
  assign fin_go        = (st_r == S_FIN) && (mode_mul_r || !out_vld_r || out_chan.ready);

  // Token issue into the first cell.
  always_comb begin
    tok_w[0].vld = (st_r == S_RUN) && (iss_r < total);
    tok_w[0].mul = mode_mul_r;
    tok_w[0].row = mode_mul_r ? iss_r[3:2] : iss_r[1:0];
    tok_w[0].col = iss_r[1:0];
    acc_w[0]     = '0;
  end

  always_comb begin
    col_ld = (!rst_n) ||
             (in_acc && (in_chan.kind == KIND_IDENTITY || in_chan.kind == KIND_TRANSPOSE)) ||
             (fin_go && mode_mul_r);
    for (int j = 0; j < 4; j++) begin
      ctl_w[j].t_en   = in_acc && (in_chan.kind == KIND_LOAD_T) && (in_chan.col_index == 2'(j));
      ctl_w[j].t_idx  = in_chan.row_index;
      ctl_w[j].o_en   = in_acc && (in_chan.kind == KIND_LOAD_O) && (in_chan.row_index == 2'(j));
      ctl_w[j].o_idx  = in_chan.col_index;
      ctl_w[j].col_ld = col_ld;
      for (int r = 0; r < 4; r++) begin
        if (!rst_n || (in_acc && in_chan.kind == KIND_IDENTITY)) begin
          ld_w[j][r] = (r == j) ? one_val : '0;
        end else if (in_acc && in_chan.kind == KIND_TRANSPOSE) begin
          ld_w[j][r] = cols_w[r][j];
        end else begin
          ld_w[j][r] = newm_r[r*4 + j];
        end
      end
    end
  end

  for (genvar j = 0; j < 4; j++) begin : g_cell
    mt4_cell #(.EW(EW), .OW(OW), .AW(AW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl_w[j]),
      .wr_val (load_val),
      .ld_col (ld_w[j]),
      .vec_i  (signed'(vec_r[j])),
      .tok_i  (tok_w[j]),
      .acc_i  (acc_w[j]),
      .tok_o  (tok_w[j+1]),
      .acc_o  (acc_w[j+1]),
      .col_o  (cols_w[j])
    );
  end

  // Scale back by the fraction bits and clip to the target width.
  always_comb begin
    sh    = acc_w[4] >>> FRAC_BITS;
    fit32 = (sh[AW-1:31] == {(AW-31){sh[31]}});
    fitew = (sh[AW-1:EW-1] == {(AW-EW+1){sh[EW-1]}});
    sat32 = fit32 ? sh[31:0] : (sh[AW-1] ? 32'h8000_0000 : 32'h7fff_ffff);
    satew = fitew ? sh[EW-1:0] :
            (sh[AW-1] ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}});
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (in_acc && (in_chan.kind == KIND_MULTIPLY ||
                             in_chan.kind == KIND_TRANSFORM)) st_nxt = S_RUN;
      S_RUN:  if (tok_w[4].vld && ret_r == total - 5'd1) st_nxt = S_FIN;
      S_FIN:  if (fin_go) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      iss_r     <= '0;
      ret_r     <= '0;
      out_vld_r <= 1'b0;
      mode_mul_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (in_acc) begin
        iss_r      <= '0;
        ret_r      <= '0;
        mode_mul_r <= (in_chan.kind == KIND_MULTIPLY);
      end else begin
        if (tok_w[0].vld) iss_r <= iss_r + 5'd1;
        if (tok_w[4].vld) ret_r <= ret_r + 5'd1;
      end
      if (fin_go && !mode_mul_r) begin
        out_vld_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_chan.kind == KIND_TRANSFORM) begin
      vec_r[0] <= OW'(in_chan.vec_x);
      vec_r[1] <= OW'(in_chan.vec_y);
      vec_r[2] <= OW'(in_chan.vec_z);
      vec_r[3] <= OW'(in_chan.vec_w);
      sat_r    <= 1'b0;
    end else if (tok_w[4].vld && !tok_w[4].mul) begin
      res_r[tok_w[4].row] <= sat32;
      sat_r <= sat_r | !fit32;
    end
    if (tok_w[4].vld && tok_w[4].mul) begin
      newm_r[{tok_w[4].row, tok_w[4].col}] <= satew;
    end
    if (fin_go && !mode_mul_r) begin
      out_r     <= res_r;
      out_sat_r <= sat_r;
    end
  end

  assign out_chan.valid     = out_vld_r;
  assign out_chan.out_x     = out_r[0];
  assign out_chan.out_y     = out_r[1];
  assign out_chan.out_z     = out_r[2];
  assign out_chan.out_w     = out_r[3];
  assign out_chan.saturated = out_sat_r;

`ifndef SYNTHESIS
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> $past(st_r == S_FIN))
    else $error("result raised outside the finish state");
  a_tokens_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    tok_w[4].vld |-> (st_r == S_RUN))
    else $error("token left the chain outside a run");
  a_ret_le_iss: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_RUN) |-> (ret_r <= iss_r))
    else $error("more tokens returned than issued");
`endif

endmodule

// File: hdl/mt4_cell.sv
// Column cell: holds one column of the transform and one row of the operand, one MAC.
`timescale 1ns / 1ps

module mt4_cell import mt4_pkg::*; #(
  parameter int EW = ELEM_WIDTH_DEF,
  parameter int OW = 32,
  parameter int AW = EW + OW + 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cell_ctl_t             ctl,
  input  logic [EW-1:0]         wr_val,
  input  logic [3:0][EW-1:0]    ld_col,
  input  logic signed [OW-1:0]  vec_i,
  input  tok_t                  tok_i,
  input  logic signed [AW-1:0]  acc_i,
  output tok_t                  tok_o,
  output logic signed [AW-1:0]  acc_o,
  output logic [3:0][EW-1:0]    col_o
);

  logic [3:0][EW-1:0]       t_col_r;
  logic [3:0][EW-1:0]       o_row_r;
  logic signed [EW-1:0]     op_a;
  logic signed [EW-1:0]     o_elem;
  logic signed [OW-1:0]     op_b;
  logic signed [EW+OW-1:0]  prod_r;
  logic signed [AW-1:0]     acc1_r;
  logic signed [AW-1:0]     acc2_r;
  tok_t                     tok1_r;
  tok_t                     tok2_r;

  always_ff @(posedge clk) begin
    if (ctl.col_ld) begin
      t_col_r <= ld_col;
    end else if (ctl.t_en) begin
      t_col_r[ctl.t_idx] <= wr_val;
    end
    if (ctl.o_en) begin
      o_row_r[ctl.o_idx] <= wr_val;
    end
  end

  always_comb begin
    op_a   = t_col_r[tok_i.row];
    o_elem = o_row_r[tok_i.col];
    op_b   = tok_i.mul ? OW'(o_elem) : vec_i;
  end

  // Stage one multiplies, stage two adds to the partial sum from the previous cell.
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    acc1_r <= acc_i;
    acc2_r <= acc1_r + AW'(prod_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok1_r <= '0;
      tok2_r <= '0;
    end else begin
      tok1_r <= tok_i;
      tok2_r <= tok1_r;
    end
  end

  assign tok_o = tok2_r;
  assign acc_o = acc2_r;
  assign col_o = t_col_r;

endmodule

// File: verif/mt4_tb_if.sv
// Testbench-side notes: the channel interfaces come from the RTL; this file holds shared test types.
`timescale 1ns / 1ps

package mt4_tb_pkg;
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
    logic               sat;
  } vec_result_t;
endpackage

// File: verif/matrix4_transform_engine_core_tb.sv
// Self-checking testbench for the 4x4 matrix transform engine core.
`timescale 1ns / 1ps

module matrix4_transform_engine_core_tb;
  import mt4_pkg::*;
  import mt4_tb_pkg::*;

  // Tracks the matrix contents and queues the transformed vectors they imply.
  class xform_scoreboard;
    logic signed [31:0] tmat [16];
    logic signed [31:0] omat [16];
    vec_result_t        pending [$];
    int                 mismatches;
    int                 checked;

    function void clear();
      for (int i = 0; i < 16; i++) begin
        tmat[i] = (i[3:2] == i[1:0]) ? 32'sh0001_0000 : 32'sd0;
        omat[i] = 32'sd0;
      end
    endfunction

    function logic signed [31:0] clip32(logic signed [127:0] acc, inout logic hit);
      logic signed [127:0] s;
      s = acc >>> FRAC_BITS_DEF;
      if (s > 128'sh7fff_ffff) begin
        hit = 1'b1;
        return 32'sh7fff_ffff;
      end
      if (s < -128'sh8000_0000) begin
        hit = 1'b1;
        return 32'sh8000_0000;
      end
      return s[31:0];
    endfunction

    function void note_command(logic [2:0] kind, logic [1:0] r, logic [1:0] c,
                               logic signed [31:0] ev, logic signed [31:0] v [4]);
      logic signed [31:0]  nt [16];
      logic signed [127:0] acc;
      logic                hit;
      vec_result_t         res;
      logic signed [31:0]  o [4];
      hit = 1'b0;
      case (kind)
        KIND_LOAD_T: tmat[{r, c}] = ev;
        KIND_LOAD_O: omat[{r, c}] = ev;
        KIND_IDENTITY: begin
          for (int i = 0; i < 16; i++)
            tmat[i] = (i[3:2] == i[1:0]) ? 32'sh0001_0000 : 32'sd0;
        end
        KIND_TRANSPOSE: begin
          for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++) nt[j*4+i] = tmat[i*4+j];
          tmat = nt;
        end
        KIND_MULTIPLY: begin
          for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++) begin
              acc = 0;
              for (int k = 0; k < 4; k++)
                acc += 128'(tmat[i*4+k]) * 128'(omat[k*4+j]);
              nt[i*4+j] = clip32(acc, hit);
            end
          tmat = nt;
        end
        KIND_TRANSFORM: begin
          for (int i = 0; i < 4; i++) begin
            acc = 0;
            for (int k = 0; k < 4; k++) acc += 128'(tmat[i*4+k]) * 128'(v[k]);
            o[i] = clip32(acc, hit);
          end
          res.x = o[0]; res.y = o[1]; res.z = o[2]; res.w = o[3]; res.sat = hit;
          pending.push_back(res);
        end
        default: ;
      endcase
    endfunction

    function void check_result(vec_result_t got);
      vec_result_t exp_r;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction at %0t", $realtime);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp %h %h %h %h sat %b, got %h %h %h %h sat %b",
                   exp_r.x, exp_r.y, exp_r.z, exp_r.w, exp_r.sat,
                   got.x, got.y, got.z, got.w, got.sat);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  mt4_in_if  in_chan ();
  mt4_out_if out_chan ();

  matrix4_transform_engine_core dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan.sink), .out_chan(out_chan.source)
  );

  always #4 clk = ~clk;

  xform_scoreboard sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_cycles = 0;
  int n_cmds = 0;

  initial begin
    in_chan.valid = 1'b0;
    in_chan.kind = KIND_IDENTITY;
    in_chan.row_index = '0;
    in_chan.col_index = '0;
    in_chan.element_value = '0;
    in_chan.vec_x = '0;
    in_chan.vec_y = '0;
    in_chan.vec_z = '0;
    in_chan.vec_w = '0;
    out_chan.ready = 1'b0;
  end

  // Receiver: stalls at random, or holds off entirely for a counted stretch.
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    vec_result_t got;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got.x = out_chan.out_x; got.y = out_chan.out_y;
      got.z = out_chan.out_z; got.w = out_chan.out_w;
      got.sat = out_chan.saturated;
      sb.check_result(got);
    end
  end

  function automatic logic signed [31:0] rand_elem();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'sh8000_0000;
      2: return 32'sh7fff_ffff;
      default: return $signed(32'($urandom_range(32'h3_0000))) - 32'sh1_8000;
    endcase
  endfunction

  // Offers one command and waits for its transaction; valid stays high into the
  // next call so that back-to-back commands need no gap.
  task automatic send_cmd(logic [2:0] kind, logic [1:0] r, logic [1:0] c,
                          logic signed [31:0] ev, logic signed [31:0] v [4]);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.kind <= kind;
    in_chan.row_index <= r;
    in_chan.col_index <= c;
    in_chan.element_value <= ev;
    in_chan.vec_x <= v[0];
    in_chan.vec_y <= v[1];
    in_chan.vec_z <= v[2];
    in_chan.vec_w <= v[3];
    do @(posedge clk); while (!in_chan.ready);
    sb.note_command(kind, r, c, ev, v);
    n_cmds++;
    @(negedge clk);
  endtask

  task automatic send_random(int count);
    logic signed [31:0] v [4];
    logic [2:0] kind;
    for (int n = 0; n < count; n++) begin
      for (int k = 0; k < 4; k++) v[k] = rand_elem();
      case ($urandom_range(19))
        0, 1, 2, 3, 4: kind = KIND_LOAD_T;
        5, 6, 7:       kind = KIND_LOAD_O;
        8:             kind = KIND_IDENTITY;
        9:             kind = KIND_TRANSPOSE;
        10, 11:        kind = KIND_MULTIPLY;
        12:            kind = 3'($urandom_range(7, 6));
        default:       kind = KIND_TRANSFORM;
      endcase
      send_cmd(kind, 2'($urandom), 2'($urandom), rand_elem(), v);
    end
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    logic signed [31:0] v [4];
    sb = new();
    sb.clear();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: identity transform at the extremes, then every command kind.
    v = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh0001_0000, -32'sh0001_0000};
    send_cmd(KIND_TRANSFORM, 0, 0, 0, v);
    for (int i = 0; i < 16; i++)
      send_cmd(KIND_LOAD_O, i[3:2], i[1:0], (i % 3 == 0) ? 32'sh7fff_ffff : -i * 4096, v);
    send_cmd(KIND_LOAD_T, 3, 3, 32'sh8000_0000, v);
    send_cmd(KIND_LOAD_T, 0, 1, 32'sh7fff_ffff, v);
    send_cmd(KIND_TRANSFORM, 0, 0, 0, v);
    send_cmd(KIND_TRANSPOSE, 0, 0, 0, v);
    send_cmd(KIND_MULTIPLY, 0, 0, 0, v);
    send_cmd(3'd6, 1, 2, 32'sh1234, v);
    send_cmd(3'd7, 2, 1, 32'sh1234, v);
    send_cmd(KIND_TRANSFORM, 0, 0, 0, v);
    send_cmd(KIND_IDENTITY, 0, 0, 0, v);
    v = '{-32'sd1, 32'sd1, 32'sh5555_5555, 32'shaaaa_aaaa};
    send_cmd(KIND_TRANSFORM, 0, 0, 0, v);
    drain();

    send_random(100);
    send_idle_pct = 50;
    send_random(80);
    send_idle_pct = 0;
    recv_stall_pct = 50;
    send_random(80);
    send_idle_pct = 11;
    recv_stall_pct = 11;
    send_random(80);

    // Long receiver hold-off while transforms keep arriving.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 300;
    for (int n = 0; n < 20; n++) begin
      for (int k = 0; k < 4; k++) v[k] = rand_elem();
      send_cmd(KIND_TRANSFORM, 0, 0, 0, v);
    end
    send_random(60);
    drain();

    $display("Ran %0d command transactions and checked %0d transformed vectors,",
             n_cmds, sb.checked);
    $display("covering every command kind, saturation and sender/receiver idling.");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results outstanding", sb.mismatches,
               sb.pending.size());
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout");
    $display("status: fail");
    $finish;
  end

endmodule

// File: filelist.f
hdl/mt4_pkg.sv
hdl/mt4_in_if.sv
hdl/mt4_out_if.sv
hdl/mt4_cell.sv
hdl/matrix4_transform_engine_core.sv
verif/mt4_tb_if.sv
verif/matrix4_transform_engine_core_tb.sv
